/* design/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg - buddy block allocator shared definitions
// Widths, status and function codes, and the free map word layout
// ----------------------------------------------------------------------------
package bba_pkg;

    // block levels and offsets
    localparam int MAX_LEVEL  = 10;
    localparam int LEVEL_W    = 4;
    localparam int OFF_W      = 10;
    localparam int STATUS_W   = 2;

    // free map is packed into words of this many block bits
    localparam int WORD_SHIFT = 5;
    localparam int WORD_BITS  = 1 << WORD_SHIFT;
    localparam int WIDX_W     = OFF_W - WORD_SHIFT;

    // words needed for one level of the free map
    function automatic int level_words(int lvl);
        int bits;
        bits = 1 << (MAX_LEVEL - lvl);
        return (bits > WORD_BITS) ? (bits >> WORD_SHIFT) : 1;
    endfunction

    // words needed for all levels
    function automatic int map_words();
        int total;
        total = 0;
        for (int k = 0; k <= MAX_LEVEL; k++) begin
            total += level_words(k);
        end
        return total;
    endfunction

    localparam int MAP_WORDS = map_words();
    localparam int ADDR_W    = $clog2(MAP_WORDS);

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [WIDX_W-1:0]     t_widx;
    typedef logic [LEVEL_W-1:0]    t_level;
    typedef logic [OFF_W-1:0]      t_off;
    typedef logic [STATUS_W-1:0]   t_status;

    typedef t_addr t_base_tab [MAX_LEVEL+1];
    typedef t_widx t_last_tab [MAX_LEVEL+1];

    // first word address of each level
    function automatic t_base_tab calc_base();
        t_base_tab tab;
        int        sum;
        sum = 0;
        for (int k = 0; k <= MAX_LEVEL; k++) begin
            tab[k] = ADDR_W'(sum);
            sum += level_words(k);
        end
        return tab;
    endfunction

    // index of the last word within each level
    function automatic t_last_tab calc_last();
        t_last_tab tab;
        for (int k = 0; k <= MAX_LEVEL; k++) begin
            tab[k] = WIDX_W'(level_words(k) - 1);
        end
        return tab;
    endfunction

    localparam t_base_tab LEVEL_BASE = calc_base();
    localparam t_last_tab LEVEL_LAST = calc_last();

    // register limits
    localparam t_level MAX_TOP   = LEVEL_W'(MAX_LEVEL);
    localparam t_level TOP_RESET = LEVEL_W'(10);

    // function codes
    localparam logic FN_SPLIT   = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    // status codes
    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_BAD   = 2'd2;

endpackage

/* design/bba_ram.sv */
// ----------------------------------------------------------------------------
// bba_ram - generic simple dual port ram
// One write port, one read port, read data registered
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator - buddy allocator core with a bitmap free map
// Splits the lowest free block of a level, releases and merges with buddies
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            word
//  -------  ---  -------------------  -----------------------------------------
//  input    in   i_valid / o_stall    i_func, i_block_level, i_block_offset
//  result   out  o_valid / i_stall    o_status, o_out_offset, o_out_level
//  config   in   i_cfg_we             i_cfg_data (top_level)
//
//  after reset a clearing pass zeroes all MAP_WORDS (68) words of the free map ram
//  each free map access is a read then evaluate/write pair (S_RD, S_EV)
//  split: one access per map word searched at the level (up to 16), then the pair write
//  release: one access per level from block level to top (duplicate check),
//  one per merge; one item at a time through the sequencer
//  a finished word waits in the output register; a new word is taken meanwhile
//
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  t_level  i_cfg_data,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic    i_func,
    input  t_level  i_block_level,
    input  t_off    i_block_offset,
    output logic    o_valid,
    input  logic    i_stall,
    output t_status o_status,
    output t_off    o_out_offset,
    output t_level  o_out_level
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_EV    = 5'b01000,
        S_HOLD  = 5'b10000
    } t_state;

    typedef enum logic [4:0] {
        OP_SCAN  = 5'b00001,
        OP_PAIR  = 5'b00010,
        OP_CHECK = 5'b00100,
        OP_MERGE = 5'b01000,
        OP_MARK  = 5'b10000
    } t_op;

    // control state
    t_state  r_state, n_state;
    t_op     r_op, n_op;
    t_addr   r_clr, n_clr;
    t_level  r_top_level, n_top_level;
    logic    r_o_valid, n_o_valid;

    // working and result payload
    t_level  r_lvl, n_lvl;
    t_off    r_off, n_off;
    t_level  r_rel_lvl, n_rel_lvl;
    t_level  r_top, n_top;
    t_status r_res_status, n_res_status;
    t_off    r_res_off, n_res_off;
    t_level  r_res_lvl, n_res_lvl;
    t_status r_o_status, n_o_status;
    t_off    r_o_off, n_o_off;
    t_level  r_o_lvl, n_o_lvl;

    // ram ports
    logic    ram_we;
    t_addr   ram_waddr;
    t_word   ram_wdata;
    t_word   ram_rdata;

    // shared address unit
    t_off                  u_off;
    t_off                  u_blk;
    t_widx                 u_widx;
    logic [WORD_SHIFT-1:0] u_bit;
    logic [WORD_SHIFT-1:0] u_own_bit;
    t_addr                 u_addr;
    t_word                 u_mask;

    // search and request checks
    logic                  pick_found;
    logic [WORD_SHIFT-1:0] pick_bit;
    t_off                  pick_off;
    t_off                  scan_next;
    logic                  scan_last;
    t_level                top_eff;
    t_off                  lvl_mask;
    logic                  split_bad;
    logic                  rel_bad;
    t_level                lvl_up;

    // lowest set bit of a map word
    function automatic logic [WORD_SHIFT-1:0] first_set(t_word w);
        logic [WORD_SHIFT-1:0] idx;
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (w[k]) begin
                idx = WORD_SHIFT'(k);
            end
        end
        return idx;
    endfunction

    // free map storage
    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (u_addr),
        .o_rdata (ram_rdata)
    );

    // block offset to map word address and bit, buddy during merge
    assign u_off     = (r_op == OP_MERGE) ? (r_off ^ (t_off'(1) << r_lvl)) : r_off;
    assign u_blk     = u_off >> r_lvl;
    assign u_widx    = u_blk[OFF_W-1:WORD_SHIFT];
    assign u_bit     = u_blk[WORD_SHIFT-1:0];
    assign u_own_bit = {u_bit[WORD_SHIFT-1:1], ~u_bit[0]};
    assign u_addr    = LEVEL_BASE[r_lvl] + t_addr'(u_widx);
    assign u_mask    = t_word'(1) << u_bit;
    assign lvl_up    = t_level'(r_lvl + 1'b1);

    // split search over the words of one level
    assign pick_found = |ram_rdata;
    assign pick_bit   = first_set(ram_rdata);
    assign pick_off   = t_off'({u_widx, pick_bit}) << r_lvl;
    assign scan_next  = t_off'({t_widx'(u_widx + 1'b1), {WORD_SHIFT{1'b0}}}) << r_lvl;
    assign scan_last  = (u_widx == LEVEL_LAST[r_lvl]);

    // request checks at accept
    assign top_eff   = (r_top_level > MAX_TOP) ? MAX_TOP : r_top_level;
    assign lvl_mask  = ~({OFF_W{1'b1}} << i_block_level);
    assign split_bad = (i_block_level == '0) || (i_block_level > top_eff);
    assign rel_bad   = (i_block_level > top_eff) || ((i_block_offset & lvl_mask) != '0) ||
                       ((i_block_offset >> top_eff) != '0);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_clr        = r_clr;
        n_top_level  = r_top_level;
        n_lvl        = r_lvl;
        n_off        = r_off;
        n_rel_lvl    = r_rel_lvl;
        n_top        = r_top;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_res_lvl    = r_res_lvl;
        n_o_valid    = r_o_valid && i_stall;
        n_o_status   = r_o_status;
        n_o_off      = r_o_off;
        n_o_lvl      = r_o_lvl;
        ram_we       = 1'b0;
        ram_waddr    = u_addr;
        ram_wdata    = ram_rdata;

        // config register
        if (i_cfg_we) begin
            n_top_level = i_cfg_data;
        end

        unique case (r_state)
            // zero the free map after reset
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = t_addr'(r_clr + 1'b1);
                if (r_clr == t_addr'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // take a word and check it
            S_IDLE: begin
                if (i_valid) begin
                    n_top     = top_eff;
                    n_lvl     = i_block_level;
                    n_rel_lvl = i_block_level;
                    n_res_off = '0;
                    n_res_lvl = '0;
                    if (i_func == FN_SPLIT) begin
                        n_off = '0;
                        if (split_bad) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_HOLD;
                        end else begin
                            n_op    = OP_SCAN;
                            n_state = S_RD;
                        end
                    end else begin
                        n_off = i_block_offset;
                        if (rel_bad) begin
                            n_res_status = ST_BAD;
                            n_state      = S_HOLD;
                        end else begin
                            n_op    = OP_CHECK;
                            n_state = S_RD;
                        end
                    end
                end
            end
            // map word read in flight
            S_RD: begin
                n_state = S_EV;
            end
            // evaluate the map word, update it
            S_EV: begin
                unique case (r_op)
                    OP_SCAN: begin
                        if (pick_found) begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~(t_word'(1) << pick_bit);
                            n_off     = pick_off;
                            n_lvl     = t_level'(r_lvl - 1'b1);
                            n_op      = OP_PAIR;
                            n_state   = S_RD;
                        end else if (scan_last) begin
                            n_res_status = ST_EMPTY;
                            n_res_off    = '0;
                            n_res_lvl    = '0;
                            n_state      = S_HOLD;
                        end else begin
                            n_off   = scan_next;
                            n_state = S_RD;
                        end
                    end
                    OP_PAIR: begin
                        ram_we       = 1'b1;
                        ram_wdata    = ram_rdata | (t_word'(3) << u_bit);
                        n_res_status = ST_DONE;
                        n_res_off    = r_off;
                        n_res_lvl    = r_lvl;
                        n_state      = S_HOLD;
                    end
                    OP_CHECK: begin
                        if ((ram_rdata & u_mask) != '0) begin
                            n_res_status = ST_BAD;
                            n_res_off    = '0;
                            n_res_lvl    = '0;
                            n_state      = S_HOLD;
                        end else if (r_lvl == r_top) begin
                            n_lvl   = r_rel_lvl;
                            n_op    = (r_rel_lvl == r_top) ? OP_MARK : OP_MERGE;
                            n_state = S_RD;
                        end else begin
                            n_lvl   = lvl_up;
                            n_state = S_RD;
                        end
                    end
                    OP_MERGE: begin
                        if ((ram_rdata & u_mask) != '0) begin
                            // buddy free: take it and climb
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~u_mask;
                            n_off     = r_off & ~(t_off'(1) << r_lvl);
                            n_lvl     = lvl_up;
                            if (lvl_up == r_top) begin
                                n_op = OP_MARK;
                            end
                            n_state = S_RD;
                        end else begin
                            // own bit shares the buddy's word
                            ram_we       = 1'b1;
                            ram_wdata    = ram_rdata | (t_word'(1) << u_own_bit);
                            n_res_status = ST_DONE;
                            n_res_off    = r_off;
                            n_res_lvl    = r_lvl;
                            n_state      = S_HOLD;
                        end
                    end
                    OP_MARK: begin
                        ram_we       = 1'b1;
                        ram_wdata    = ram_rdata | u_mask;
                        n_res_status = ST_DONE;
                        n_res_off    = r_off;
                        n_res_lvl    = r_lvl;
                        n_state      = S_HOLD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            // hand the result to the output register
            S_HOLD: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_off    = r_res_off;
                    n_o_lvl    = r_res_lvl;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_op        <= OP_SCAN;
            r_clr       <= '0;
            r_top_level <= TOP_RESET;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_clr       <= n_clr;
            r_top_level <= n_top_level;
            r_o_valid   <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lvl        <= n_lvl;
        r_off        <= n_off;
        r_rel_lvl    <= n_rel_lvl;
        r_top        <= n_top;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_lvl    <= n_res_lvl;
        r_o_status   <= n_o_status;
        r_o_off      <= n_o_off;
        r_o_lvl      <= n_o_lvl;
    end

    // outputs
    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_out_offset = r_o_off;
    assign o_out_level  = r_o_lvl;

`ifndef SYNTHESIS
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (ram_we && (ram_wdata == '0)))
        else $error("clearing pass does not write zero");

    a_lvl_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_EV)) |-> (r_lvl <= r_top))
        else $error("working level above top level");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("accepted word did not start the sequencer");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_DONE)) |-> ((o_out_offset == '0) && (o_out_level == '0)))
        else $error("failed result carries offset or level");
`endif

endmodule
